FILE: src/ttdr_pkg.sv
// Shared types and constants for the touch tap/drag recognizer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ttdr_pkg;

    localparam int TOUCH_SLOTS = 16;
    localparam int COORD_BITS  = 16;
    localparam int ID_BITS     = 4;
    localparam int CFG_IDX_BITS = 2;

    // Drag threshold and its square; a motion's squared distance must exceed the square to count as a drag
    localparam int DRAG_LIMIT    = 5;
    localparam int DRAG_LIMIT_SQ = DRAG_LIMIT * DRAG_LIMIT;

    // Command codes
    localparam logic CMD_TOUCH = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOUCH_ENABLED  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRAG_X_ALLOWED = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRAG_Y_ALLOWED = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [ID_BITS-1:0]           touch_id_t;

    typedef struct packed {
        logic      command;
        touch_id_t touch_id;
        coord_t    pos_x;
        coord_t    pos_y;
        logic      pressed;
        logic      moved;
        logic      abort;
        logic      inside_req;
    } in_item_t;

    typedef struct packed {
        logic   accepted;
        logic   is_active;
        logic   is_hover;
        logic   is_drag;
        logic   trigger_down;
        logic   trigger_up;
        coord_t current_x;
        coord_t current_y;
    } out_item_t;

    typedef struct packed {
        logic touch_enabled;
        logic drag_x_allowed;
        logic drag_y_allowed;
    } cfg_t;

endpackage

FILE: src/ttdr_if.sv
// Valid/ready channel interfaces for touch events and result items.
// Depends on ttdr_pkg for the payload types.
`timescale 1ns / 1ps

interface ttdr_evt_if;
    import ttdr_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ttdr_res_if;
    import ttdr_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/ttdr_drag_test.sv
// Drag decision: distance from the start point against the threshold,
// then the allowed-axis test. Depends on ttdr_pkg.
`timescale 1ns / 1ps

module ttdr_drag_test (
    input  ttdr_pkg::coord_t pos_x,
    input  ttdr_pkg::coord_t pos_y,
    input  ttdr_pkg::coord_t start_x,
    input  ttdr_pkg::coord_t start_y,
    input  ttdr_pkg::cfg_t   cfg,
    output logic             drag_hit
);
    import ttdr_pkg::*;

    localparam int DW = COORD_BITS + 1;

    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0]        ax, ay;
    logic [2:0]           sx, sy;
    logic [6:0]           sq_sum;
    logic                 far;

    assign dx = DW'(pos_x) - DW'(start_x);
    assign dy = DW'(pos_y) - DW'(start_y);
    assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);

    // Beyond the limit on one axis is always far; otherwise square the small parts
    assign sx     = ax[2:0];
    assign sy     = ay[2:0];
    assign sq_sum = 7'(sx * sx) + 7'(sy * sy);
    assign far    = (ax > DW'(DRAG_LIMIT)) || (ay > DW'(DRAG_LIMIT))
                    || (sq_sum > 7'(DRAG_LIMIT_SQ));

    always_comb
    begin
        drag_hit = 1'b0;
        if (far)
        begin
            if (cfg.drag_x_allowed && cfg.drag_y_allowed)
                drag_hit = 1'b1;
            else if (cfg.drag_x_allowed && (ax > ay))
                drag_hit = 1'b1;
            else if (cfg.drag_y_allowed && (ax < ay))
                drag_hit = 1'b1;
        end
    end

endmodule

FILE: src/ttdr_core.sv
// Touch tracking state and the per-event update; state advances once per item.
// Depends on ttdr_pkg and ttdr_drag_test.
`timescale 1ns / 1ps

module ttdr_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  ttdr_pkg::in_item_t  item,
    input  ttdr_pkg::cfg_t      cfg,
    output ttdr_pkg::out_item_t result
);
    import ttdr_pkg::*;

    logic      active_reg, active_next;
    logic      hover_reg, hover_next;
    logic      drag_reg, drag_next;
    logic      down_reg, down_next;
    logic      up_reg, up_next;
    touch_id_t owner_reg, owner_next;
    coord_t    start_x_reg, start_x_next;
    coord_t    start_y_reg, start_y_next;
    coord_t    last_x_reg, last_x_next;
    coord_t    last_y_reg, last_y_next;

    logic accepted, trig_up, cancel, slot_ok, drag_hit;

    ttdr_drag_test u_drag (
        .pos_x   (item.pos_x),
        .pos_y   (item.pos_y),
        .start_x (start_x_reg),
        .start_y (start_y_reg),
        .cfg     (cfg),
        .drag_hit(drag_hit)
    );

    assign cancel  = item.abort || !cfg.touch_enabled;
    assign slot_ok = int'(item.touch_id) < TOUCH_SLOTS;

    always_comb
    begin
        active_next  = active_reg;
        hover_next   = hover_reg;
        drag_next    = drag_reg;
        down_next    = down_reg;
        up_next      = up_reg;
        owner_next   = owner_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        accepted     = 1'b0;
        trig_up      = 1'b0;

        if (item.command == CMD_QUERY)
        begin
            trig_up = up_reg;
            up_next = 1'b0;
        end
        else if (slot_ok)
        begin
            if (!active_reg)
            begin
                if (item.pressed && !item.moved && !cancel && item.inside_req)
                begin
                    owner_next   = item.touch_id;
                    active_next  = 1'b1;
                    hover_next   = 1'b1;
                    drag_next    = 1'b0;
                    down_next    = 1'b1;
                    start_x_next = item.pos_x;
                    start_y_next = item.pos_y;
                    last_x_next  = item.pos_x;
                    last_y_next  = item.pos_y;
                    accepted     = 1'b1;
                end
            end
            else if (owner_reg == item.touch_id)
            begin
                last_x_next = item.pos_x;
                last_y_next = item.pos_y;
                if (cancel)
                begin
                    active_next = 1'b0;
                    hover_next  = 1'b0;
                end
                else if (item.pressed)
                begin
                    hover_next = item.inside_req;
                    if (item.moved && !drag_reg && drag_hit)
                        drag_next = 1'b1;
                    accepted = 1'b1;
                end
                else
                begin
                    active_next = 1'b0;
                    hover_next  = 1'b0;
                    if (item.inside_req)
                        up_next = 1'b1;
                    accepted = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result.accepted     = accepted;
        result.is_active    = active_next;
        result.is_hover     = hover_next;
        result.is_drag      = drag_next;
        result.trigger_down = down_next;
        result.trigger_up   = trig_up;
        result.current_x    = last_x_next;
        result.current_y    = last_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            hover_reg   <= 1'b0;
            drag_reg    <= 1'b0;
            down_reg    <= 1'b0;
            up_reg      <= 1'b0;
            owner_reg   <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
        end
        else if (advance)
        begin
            active_reg  <= active_next;
            hover_reg   <= hover_next;
            drag_reg    <= drag_next;
            down_reg    <= down_next;
            up_reg      <= up_next;
            owner_reg   <= owner_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
        end
    end

endmodule

FILE: src/touch_tap_drag_recognizer.sv
// Top level of the touch tap/drag recognizer: input register, tracking core,
// result register and configuration registers.
// Depends on ttdr_pkg, ttdr_if (ttdr_evt_if, ttdr_res_if) and ttdr_core.
//
// Usage:
//   evt  - sink channel of touch events and query commands (valid/ready).
//   res  - source channel; exactly one result item per accepted item, in order.
//   cfg_we/cfg_index/cfg_wdata - write-only configuration; write while idle.
// Timing:
//   An accepted item is held in the input register, passes through the tracking
//   update and is loaded into the result register when that register is free or
//   being drained. One item per clock is sustained while res takes results; the
//   single state update between the two registers sets that rate.
// Stall:
//   While res is stalled the result register holds; one more item may wait in
//   the input register, after which evt.ready drops until res drains.
// Reset:
//   Clears all tracking state (no touch claimed, flags low, points at zero),
//   empties both registers, and sets touch enabled with both drag axes off.
`timescale 1ns / 1ps

module touch_tap_drag_recognizer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    ttdr_evt_if.sink                              evt,
    ttdr_res_if.source                            res,
    input  logic                                  cfg_we,
    input  logic [ttdr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic                                  cfg_wdata
);
    import ttdr_pkg::*;

    cfg_t      cfg_reg;
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t core_result;
    logic      advance;

    // Move the held item into the result register when that slot is free or being taken
    assign advance   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign evt.ready = !s1_valid_reg || advance;
    assign res.valid = out_valid_reg;
    assign res.data  = out_item_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.touch_enabled  <= 1'b1;
            cfg_reg.drag_x_allowed <= 1'b0;
            cfg_reg.drag_y_allowed <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOUCH_ENABLED:  cfg_reg.touch_enabled  <= cfg_wdata;
                CFG_DRAG_X_ALLOWED: cfg_reg.drag_x_allowed <= cfg_wdata;
                CFG_DRAG_Y_ALLOWED: cfg_reg.drag_y_allowed <= cfg_wdata;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register: valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (evt.ready)
            s1_valid_reg <= evt.valid;
    end

    // Input register: payload, loaded only on an accepted item
    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
            s1_item_reg <= evt.data;
    end

    ttdr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(advance),
        .item   (s1_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    // Result register: valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= core_result;
    end

    // A query result never reports the event as consumed
    a_query_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.trigger_up |-> !out_item_reg.accepted)
        else $error("trigger_up reported together with accepted");

    // Hover only exists for a claimed touch
    a_hover_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.is_hover |-> out_item_reg.is_active)
        else $error("hover reported without an active touch");

    // A held item is never dropped while the result side is stalled
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg)
        else $error("input register lost an item");

    // Every advance produces a visible result in the next cycle
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advance did not load the result register");

    // A stalled result keeps its payload until taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |=> out_valid_reg && $stable(out_item_reg))
        else $error("stalled result changed");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for touch_tap_drag_recognizer: drives touch events and queries on the
// valid/ready channels and checks every result against an in-bench tracking predictor.
// Depends on ttdr_pkg, ttdr_if and the recognizer RTL.
`timescale 1ns / 1ps

module tb_top;
    import ttdr_pkg::*;

    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 166;
    localparam int RX_STALL_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 250000;

    localparam coord_t COORD_MAX = 16'sh7FFF;
    localparam coord_t COORD_MIN = 16'sh8000;

    // Register settings per random phase: {touch_enabled, drag_x_allowed, drag_y_allowed}
    localparam logic [2:0] PHASE_CFG [PHASES] =
        '{3'b110, 3'b101, 3'b111, 3'b000, 3'b100, 3'b111, 3'b011, 3'b101};

    // Tracks one touch claim the way the block should and holds the results it owes.
    class touch_scoreboard;
        logic      enabled, x_allowed, y_allowed;
        logic      claimed, hovering, dragging, down_seen, up_pending;
        touch_id_t owner;
        coord_t    start_x, start_y, last_x, last_y;
        out_item_t owed_q[$];
        int        errors;

        function new();
            enabled   = 1'b1;
            x_allowed = 1'b0;
            y_allowed = 1'b0;
            claimed   = 1'b0;
            hovering  = 1'b0;
            dragging  = 1'b0;
            down_seen = 1'b0;
            up_pending = 1'b0;
            owner     = '0;
            start_x   = '0;
            start_y   = '0;
            last_x    = '0;
            last_y    = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] index, logic value);
            case (index)
                CFG_TOUCH_ENABLED:  enabled   = value;
                CFG_DRAG_X_ALLOWED: x_allowed = value;
                CFG_DRAG_Y_ALLOWED: y_allowed = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Advance the tracking state by one accepted item and queue what it must produce.
        function void note_event(in_item_t ev);
            out_item_t r;
            logic      cancel;
            longint    dx, dy, ax, ay;
            r = '0;
            cancel = ev.abort || !enabled;
            if (ev.command == CMD_QUERY) begin
                r.trigger_up = up_pending;
                up_pending = 1'b0;
            end else if (int'(ev.touch_id) < TOUCH_SLOTS) begin
                if (!claimed) begin
                    if (ev.pressed && !ev.moved && !cancel && ev.inside_req) begin
                        owner     = ev.touch_id;
                        claimed   = 1'b1;
                        hovering  = 1'b1;
                        dragging  = 1'b0;
                        down_seen = 1'b1;
                        start_x   = ev.pos_x;
                        start_y   = ev.pos_y;
                        last_x    = ev.pos_x;
                        last_y    = ev.pos_y;
                        r.accepted = 1'b1;
                    end
                end else if (owner == ev.touch_id) begin
                    if (cancel) begin
                        claimed  = 1'b0;
                        hovering = 1'b0;
                        last_x   = ev.pos_x;
                        last_y   = ev.pos_y;
                    end else if (ev.pressed) begin
                        hovering = ev.inside_req;
                        last_x   = ev.pos_x;
                        last_y   = ev.pos_y;
                        if (ev.moved && !dragging) begin
                            dx = longint'(ev.pos_x) - longint'(start_x);
                            dy = longint'(ev.pos_y) - longint'(start_y);
                            if (dx * dx + dy * dy > DRAG_LIMIT_SQ) begin
                                ax = (dx < 0) ? -dx : dx;
                                ay = (dy < 0) ? -dy : dy;
                                if (x_allowed && y_allowed)
                                    dragging = 1'b1;
                                else if (x_allowed && ax > ay)
                                    dragging = 1'b1;
                                else if (y_allowed && ax < ay)
                                    dragging = 1'b1;
                            end
                        end
                        r.accepted = 1'b1;
                    end else begin
                        claimed  = 1'b0;
                        hovering = 1'b0;
                        last_x   = ev.pos_x;
                        last_y   = ev.pos_y;
                        if (ev.inside_req)
                            up_pending = 1'b1;
                        r.accepted = 1'b1;
                    end
                end
            end
            r.is_active    = claimed;
            r.is_hover     = hovering;
            r.is_drag      = dragging;
            r.trigger_down = down_seen;
            r.current_x    = last_x;
            r.current_y    = last_y;
            owed_q.push_back(r);
        endfunction

        function void check_field(string field, coord_t want, coord_t got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_flag(string field, logic want, logic got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0b, got %0b", $time, field, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: result expected none, got %p", $time, got);
                return;
            end
            want = owed_q.pop_front();
            check_flag("accepted",     want.accepted,     got.accepted);
            check_flag("is_active",    want.is_active,    got.is_active);
            check_flag("is_hover",     want.is_hover,     got.is_hover);
            check_flag("is_drag",      want.is_drag,      got.is_drag);
            check_flag("trigger_down", want.trigger_down, got.trigger_down);
            check_flag("trigger_up",   want.trigger_up,   got.trigger_up);
            check_field("current_x",   want.current_x,    got.current_x);
            check_field("current_y",   want.current_y,    got.current_y);
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic                    cfg_wdata;

    ttdr_evt_if evt_ch ();
    ttdr_res_if res_ch ();

    touch_scoreboard books;

    // Idling controls for the sender and the receiver, and run counters
    bit          tx_no_idle;
    bit          rx_no_idle;
    bit          rx_stall_req;
    int          items_sent;
    int unsigned cycle_count = 0;

    touch_tap_drag_recognizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Kill a hung run: anything this slow is a lost handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Build a touch event with every field given.
    function automatic in_item_t touch_item(touch_id_t id, coord_t x, coord_t y,
                                            logic pressed, logic moved,
                                            logic abort_req, logic in_area);
        in_item_t ev;
        ev            = '0;
        ev.command    = CMD_TOUCH;
        ev.touch_id   = id;
        ev.pos_x      = x;
        ev.pos_y      = y;
        ev.pressed    = pressed;
        ev.moved      = moved;
        ev.abort      = abort_req;
        ev.inside_req = in_area;
        return ev;
    endfunction

    // Fully random item; either command may come out.
    function automatic in_item_t noise_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    // Query with random touch fields, which the block must ignore.
    function automatic in_item_t query_item();
        in_item_t ev;
        ev = noise_item();
        ev.command = CMD_QUERY;
        return ev;
    endfunction

    // Offer one item after a drawn gap and hold it until the block takes it.
    // Leave valid high on return so back-to-back items follow without a gap.
    task automatic send_event(input in_item_t ev);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_ch.valid <= 1'b1;
        evt_ch.data  <= ev;
        do
            @(posedge clk);
        while (!evt_ch.ready);
        books.note_event(ev);
        items_sent++;
    endtask

    // Drop valid and wait until every owed result is back, then let the pipe empty.
    task automatic settle();
        evt_ch.valid <= 1'b0;
        while (books.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all three registers back to back; the block must be idle.
    task automatic apply_settings(input logic en, input logic x_ok, input logic y_ok);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TOUCH_ENABLED;
        cfg_wdata <= en;
        @(posedge clk);
        books.write_reg(CFG_TOUCH_ENABLED, en);
        cfg_index <= CFG_DRAG_X_ALLOWED;
        cfg_wdata <= x_ok;
        @(posedge clk);
        books.write_reg(CFG_DRAG_X_ALLOWED, x_ok);
        cfg_index <= CFG_DRAG_Y_ALLOWED;
        cfg_wdata <= y_ok;
        @(posedge clk);
        books.write_reg(CFG_DRAG_Y_ALLOWED, y_ok);
        cfg_we <= 1'b0;
    endtask

    // One press-move-release gesture with random content. Most starts are clean so the
    // claim is taken; some are broken, some gestures get foreign-id noise, aborts, or
    // are left hanging.
    task automatic run_gesture();
        touch_id_t id, other;
        coord_t    sx, sy, px, py;
        int        span, off_x, off_y, moves, ending;
        id = touch_id_t'($urandom_range(0, TOUCH_SLOTS - 1));
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        case ($urandom_range(0, 9))
            0:       send_event(touch_item(id, sx, sy, 1'b1, 1'b1, 1'b0, 1'b1));
            1:       send_event(touch_item(id, sx, sy, 1'b1, 1'b0, 1'b0, 1'b0));
            2:       send_event(touch_item(id, sx, sy, 1'b1, 1'b0, 1'b1, 1'b1));
            default: send_event(touch_item(id, sx, sy, 1'b1, 1'b0, 1'b0, 1'b1));
        endcase
        px = sx;
        py = sy;
        moves = $urandom_range(0, 6);
        repeat (moves) begin
            if ($urandom_range(0, 5) == 0) begin
                other = id + touch_id_t'($urandom_range(1, TOUCH_SLOTS - 1));
                send_event(touch_item(other, coord_t'($urandom), coord_t'($urandom),
                                      1'($urandom), 1'($urandom),
                                      1'($urandom), 1'($urandom)));
            end
            // Keep most motion near the drag threshold; sometimes jump far
            span  = ($urandom_range(0, 4) == 0) ? 300 : 7;
            off_x = int'($urandom_range(0, 2 * span)) - span;
            off_y = int'($urandom_range(0, 2 * span)) - span;
            px = sx + coord_t'(off_x);
            py = sy + coord_t'(off_y);
            send_event(touch_item(id, px, py, 1'b1, $urandom_range(0, 6) != 0,
                                  $urandom_range(0, 24) == 0, $urandom_range(0, 4) != 0));
        end
        ending = $urandom_range(0, 19);
        if (ending < 13)
            send_event(touch_item(id, px, py, 1'b0, 1'($urandom), 1'b0,
                                  $urandom_range(0, 3) != 0));
        else if (ending < 17)
            send_event(touch_item(id, px, py, 1'($urandom), 1'($urandom), 1'b1,
                                  1'($urandom)));
        if ($urandom_range(0, 1) == 0)
            send_event(query_item());
    endtask

    // Result side: draw a hold-off per item; honor a long stall request by holding
    // ready low for a counted stretch.
    initial
    begin
        int hold;
        hold = 0;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready) begin
                books.check_result(res_ch.data);
                hold = rx_no_idle ? 0 : $urandom_range(0, 9);
            end
            if (rx_stall_req) begin
                rx_stall_req = 1'b0;
                hold = RX_STALL_CYCLES;
            end
            if (hold > 0) begin
                res_ch.ready <= 1'b0;
                hold--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Main sequence: reset, directed checks at reset settings, then random phases.
    initial
    begin
        int phase_end;
        books = new();
        tx_no_idle   = 1'b0;
        rx_no_idle   = 1'b0;
        rx_stall_req = 1'b0;
        items_sent   = 0;
        evt_ch.valid <= 1'b0;
        evt_ch.data  <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_TOUCH_ENABLED;
        cfg_wdata    <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Query before anything happened: flag low
        send_event(query_item());
        // Idle and the event cannot start a touch: moved press, press outside,
        // aborted press, release
        send_event(touch_item(4'd3, 16'sd100, -16'sd100, 1'b1, 1'b1, 1'b0, 1'b1));
        send_event(touch_item(4'd3, 16'sd100, -16'sd100, 1'b1, 1'b0, 1'b0, 1'b0));
        send_event(touch_item(4'd3, 16'sd100, -16'sd100, 1'b1, 1'b0, 1'b1, 1'b1));
        send_event(touch_item(4'd3, 16'sd100, -16'sd100, 1'b0, 1'b0, 1'b0, 1'b1));
        // Claim with the top id at opposite coordinate extremes
        send_event(touch_item(4'd15, COORD_MAX, COORD_MIN, 1'b1, 1'b0, 1'b0, 1'b1));
        // Foreign id while claimed: ignored
        send_event(touch_item(4'd0, 16'sd5, 16'sd5, 1'b1, 1'b0, 1'b0, 1'b1));
        // Largest possible motion, both axes off: no drag, hover drops outside
        send_event(touch_item(4'd15, COORD_MIN, COORD_MAX, 1'b1, 1'b1, 1'b0, 1'b0));
        // Release inside raises trigger-up; the query reads and clears it
        send_event(touch_item(4'd15, COORD_MIN, COORD_MAX, 1'b0, 1'b0, 1'b0, 1'b1));
        send_event(query_item());
        send_event(query_item());
        // Cancel of the claimed touch records the point; cancel of an unclaimed id is ignored
        send_event(touch_item(4'd0, COORD_MIN, COORD_MAX, 1'b1, 1'b0, 1'b0, 1'b1));
        send_event(touch_item(4'd0, 16'sd7, -16'sd7, 1'b1, 1'b0, 1'b1, 1'b1));
        send_event(touch_item(4'd5, 16'sd9, 16'sd9, 1'b1, 1'b0, 1'b1, 1'b1));
        // Motion right at the threshold and just past it, release outside
        send_event(touch_item(4'd7, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b1));
        send_event(touch_item(4'd7, 16'sd3, 16'sd4, 1'b1, 1'b1, 1'b0, 1'b1));
        send_event(touch_item(4'd7, 16'sd5, 16'sd1, 1'b1, 1'b1, 1'b0, 1'b1));
        send_event(touch_item(4'd7, 16'sd6, 16'sd6, 1'b0, 1'b1, 1'b0, 1'b0));
        send_event(query_item());
        settle();

        for (int p = 0; p < PHASES; p++) begin
            apply_settings(PHASE_CFG[p][2], PHASE_CFG[p][1], PHASE_CFG[p][0]);
            // Vary the idling per phase so gaps land everywhere, with some clean bursts
            tx_no_idle = (p % 4 == 1) || (p == 6);
            rx_no_idle = (p % 4 == 2) || (p == 6);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end - PHASE_ITEMS / 2)
                run_gesture();
            // Hold results off while items keep coming, so the input side backs up
            if (p == 2)
                rx_stall_req = 1'b1;
            // Pause the sender until the block has given back everything it owes
            if (p == 5)
                settle();
            while (items_sent < phase_end)
                run_gesture();
            settle();
        end

        repeat (10) @(posedge clk);
        if (books.errors == 0 && books.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
src/ttdr_pkg.sv
src/ttdr_if.sv
src/ttdr_drag_test.sv
src/ttdr_core.sv
src/touch_tap_drag_recognizer.sv
bench/tb_top.sv
